[sv/number_to_led_digit_frames_defines.svh]
// Assertion macros shared by the RTL files.
// Both macros compile to nothing when SYNTH is defined.
`ifndef NUMBER_TO_LED_DIGIT_FRAMES_DEFINES_SVH
`define NUMBER_TO_LED_DIGIT_FRAMES_DEFINES_SVH

`ifndef SYNTH
// prop must hold at every clock edge outside reset
`define NLD_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("nld assertion failed");
// expr must never be true outside reset
`define NLD_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("nld forbidden condition seen");
`else
`define NLD_ASSERT(lbl, clk, rst_n, prop)
`define NLD_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

[sv/nld_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package nld_pkg;

    localparam int MAX_DIGITS = 4;
    localparam int ADDR_SLOTS = 4;
    localparam int DIGIT_CAP  = (MAX_DIGITS < ADDR_SLOTS) ? MAX_DIGITS : ADDR_SLOTS;
    localparam int IDX_W      = $clog2(ADDR_SLOTS);
    localparam int CNT_W      = 3;
    localparam int MAG_W      = 14;   // holds 9999
    localparam int FRAC_W     = 28;   // 2^28 > 10^8 keeps every digit exact
    localparam int RECIP_W    = 25;
    localparam int QDEPTH     = 2;

    localparam logic [7:0] DOT_BIT = 8'h80;

    // configuration register indexes
    localparam logic [2:0] CFG_DIGIT_COUNT  = 3'd0;
    localparam logic [2:0] CFG_DIGIT_ADDR_0 = 3'd1;
    localparam logic [2:0] CFG_DIGIT_ADDR_1 = 3'd2;
    localparam logic [2:0] CFG_DIGIT_ADDR_2 = 3'd3;
    localparam logic [2:0] CFG_DIGIT_ADDR_3 = 3'd4;

    typedef struct packed {
        logic [15:0] magnitude;
        logic [2:0]  dot_index;
    } t_in_item;

    typedef struct packed {
        logic [15:0] frame;
        logic [7:0]  digit_data;
        logic        last_frame;
    } t_out_item;

    // work item handed from the front to the back end
    typedef struct packed {
        logic [FRAC_W-1:0] frac;    // magnitude / 10^n as a binary fraction
        logic [CNT_W-1:0]  n;
        logic [2:0]        dot;
        logic              dot_ok;  // dot lands before the last digit
    } t_work;

    typedef logic [ADDR_SLOTS-1:0][7:0] t_addr_arr;

    function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] n;
        n = c;
        if (n == '0)
            n = CNT_W'(1);
        if (n > CNT_W'(DIGIT_CAP))
            n = CNT_W'(DIGIT_CAP);
        return n;
    endfunction

    // largest value n digits can show
    function automatic logic [MAG_W-1:0] sat_limit(input logic [CNT_W-1:0] n);
        logic [MAG_W-1:0] v;
        case (n)
            CNT_W'(1): v = MAG_W'(9);
            CNT_W'(2): v = MAG_W'(99);
            CNT_W'(3): v = MAG_W'(999);
            default:   v = MAG_W'(9999);
        endcase
        return v;
    endfunction

    // ceil(2^FRAC_W / 10^n)
    function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] n);
        logic [RECIP_W-1:0] v;
        case (n)
            CNT_W'(1): v = RECIP_W'(26843546);
            CNT_W'(2): v = RECIP_W'(2684355);
            CNT_W'(3): v = RECIP_W'(268436);
            default:   v = RECIP_W'(26844);
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[sv/nld_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module nld_front (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire nld_pkg::t_in_item i_data,
    output logic                   o_stall,
    input  wire logic [2:0]        i_digit_count,
    output logic                   o_push,
    output nld_pkg::t_work         o_work,
    input  wire logic              i_full
);
    import nld_pkg::*;

    logic               r_valid;
    logic [MAG_W-1:0]   r_mag;
    logic [CNT_W-1:0]   r_n;
    logic [2:0]         r_dot;
    logic               r_dot_ok;

    logic [CNT_W-1:0]   s_n;
    logic [MAG_W-1:0]   s_lim;
    logic [MAG_W-1:0]   n_mag;
    logic               n_dot_ok;
    logic               s_load_ok;
    logic [MAG_W+RECIP_W-1:0] s_prod;

    assign s_n   = eff_count(i_digit_count);
    assign s_lim = sat_limit(s_n);

    always_comb begin
        if (i_data.magnitude > {{(16-MAG_W){1'b0}}, s_lim})
            n_mag = s_lim;
        else
            n_mag = i_data.magnitude[MAG_W-1:0];
        n_dot_ok = ({1'b0, i_data.dot_index} + 4'd1) < {1'b0, s_n};
    end

    assign s_load_ok = !r_valid || !i_full;
    assign o_stall   = !s_load_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (s_load_ok) begin
            r_valid <= i_valid;
        end
        if (s_load_ok && i_valid) begin
            r_mag    <= n_mag;
            r_n      <= s_n;
            r_dot    <= i_data.dot_index;
            r_dot_ok <= n_dot_ok;
        end
    end

    // fraction = mag / 10^n, scaled by 2^FRAC_W; stays below 2^FRAC_W
    assign s_prod = {{RECIP_W{1'b0}}, r_mag} * {{MAG_W{1'b0}}, recip(r_n)};

    assign o_push        = r_valid && !i_full;
    assign o_work.frac   = s_prod[FRAC_W-1:0];
    assign o_work.n      = r_n;
    assign o_work.dot    = r_dot;
    assign o_work.dot_ok = r_dot_ok;

endmodule

`default_nettype wire

[sv/nld_fifo.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "number_to_led_digit_frames_defines.svh"

module nld_fifo (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire nld_pkg::t_work i_data,
    output logic                o_full,
    input  wire logic           i_pop,
    output nld_pkg::t_work      o_data,
    output logic                o_empty
);
    import nld_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CQ_W  = $clog2(QDEPTH + 1);

    t_work              r_mem [QDEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CQ_W-1:0]    r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] q;
        q = (p == PTR_W'(QDEPTH - 1)) ? '0 : p + PTR_W'(1);
        return q;
    endfunction

    assign o_full  = (r_count == CQ_W'(QDEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push)
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop)
                r_count <= r_count + CQ_W'(1);
            else if (i_pop && !i_push)
                r_count <= r_count - CQ_W'(1);
        end
        if (i_push)
            r_mem[r_wr_ptr] <= i_data;
    end

    `NLD_ASSERT_NEVER(a_fifo_overflow, i_clk, i_rst_n, i_push && o_full)
    `NLD_ASSERT_NEVER(a_fifo_underflow, i_clk, i_rst_n, i_pop && o_empty)
    `NLD_ASSERT(a_fifo_count, i_clk, i_rst_n, r_count <= CQ_W'(QDEPTH))

endmodule

`default_nettype wire

[sv/nld_back.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "number_to_led_digit_frames_defines.svh"

module nld_back (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_q_empty,
    input  wire nld_pkg::t_work     i_q_data,
    output logic                    o_pop,
    input  wire nld_pkg::t_addr_arr i_addr,
    output logic                    o_out_valid,
    output nld_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall
);
    import nld_pkg::*;

    logic               r_busy;
    logic [FRAC_W-1:0]  r_frac;
    logic [IDX_W-1:0]   r_idx;
    logic [CNT_W-1:0]   r_n;
    logic [2:0]         r_dot;
    logic               r_dot_ok;
    logic               r_had;
    logic               r_o_valid;
    t_out_item          r_o_data;

    logic               s_free;
    logic               s_adv;
    logic               s_last;
    logic               s_load;
    logic [FRAC_W+3:0]  s_t;
    logic [3:0]         s_digit;
    logic               s_at_dot;
    logic [7:0]         n_data;
    logic [7:0]         s_addr;

    assign s_free = !r_o_valid || !i_out_stall;
    assign s_adv  = r_busy && s_free;
    assign s_last = ({1'b0, r_idx} + CNT_W'(1)) == r_n;
    assign s_load = !i_q_empty && (!r_busy || (s_adv && s_last));
    assign o_pop  = s_load;

    // next decimal digit: integer part of frac * 10
    assign s_t      = ({4'b0, r_frac} << 3) + ({4'b0, r_frac} << 1);
    assign s_digit  = s_t[FRAC_W+3:FRAC_W];
    assign s_at_dot = (r_dot == {1'b0, r_idx});
    assign s_addr   = i_addr[r_idx];

    always_comb begin
        if (s_digit == 4'd0 && !s_at_dot && !r_had)
            n_data = 8'd0;   // leading zero blanked
        else
            n_data = {4'b0, s_digit} | ((s_at_dot && r_dot_ok) ? DOT_BIT : 8'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_load)
                r_busy <= 1'b1;
            else if (s_adv && s_last)
                r_busy <= 1'b0;
            if (s_adv)
                r_o_valid <= 1'b1;
            else if (!i_out_stall)
                r_o_valid <= 1'b0;
        end
        if (s_load) begin
            r_frac   <= i_q_data.frac;
            r_n      <= i_q_data.n;
            r_dot    <= i_q_data.dot;
            r_dot_ok <= i_q_data.dot_ok;
            r_idx    <= '0;
            r_had    <= 1'b0;
        end else if (s_adv) begin
            r_frac <= s_t[FRAC_W-1:0];
            r_idx  <= r_idx + IDX_W'(1);
            r_had  <= r_had || (s_digit != 4'd0);
        end
        if (s_adv) begin
            r_o_data.frame      <= {s_addr[6:0], n_data, 1'b0};
            r_o_data.digit_data <= n_data;
            r_o_data.last_frame <= s_last;
        end
    end

    assign o_out_valid = r_o_valid;
    assign o_out_data  = r_o_data;

    `NLD_ASSERT(a_idx_range, i_clk, i_rst_n, r_busy |-> ({1'b0, r_idx} < r_n))
    `NLD_ASSERT(a_done_idle, i_clk, i_rst_n, (s_adv && s_last && !s_load) |=> !r_busy)
    `NLD_ASSERT(a_adv_shows, i_clk, i_rst_n, s_adv |=> r_o_valid)

endmodule

`default_nettype wire

[sv/number_to_led_digit_frames.sv]
`timescale 1ns / 1ps
`default_nettype none

// Turns an unsigned number and a dot position into one 16-bit display-driver
// frame per digit, leftmost digit first, last_frame set on the final one.
// The front end takes one transaction per cycle unless it stalls on a full
// queue, clamps the value to all nines, and scales it into a binary fraction
// with one multiply; a two-entry queue sits before the back end, which,
// while the output is not stalled, peels off one decimal digit per cycle
// (multiply by ten) and writes one frame per cycle into the output register.
// digit_count is clamped to 1..4 (0 acts as 1, 5..7 as 4) and is 4 at reset.
// The back-end digit step limits throughput. An item passes the front-end
// register, the queue and the back-end registers before its first frame.
// Configuration writes are taken at any time but must only happen while idle.
module number_to_led_digit_frames (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire nld_pkg::t_in_item  i_in_data,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output nld_pkg::t_out_item      o_out_data,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_we,
    input  wire logic [2:0]         i_cfg_index,
    input  wire logic [7:0]         i_cfg_data
);
    import nld_pkg::*;

    logic [2:0]  r_digit_count;
    t_addr_arr   r_addr;

    logic        s_push;
    t_work       s_work;
    logic        s_full;
    logic        s_pop;
    t_work       s_q_data;
    logic        s_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_digit_count <= 3'(MAX_DIGITS);
            r_addr[0]     <= 8'd32;
            r_addr[1]     <= 8'd40;
            r_addr[2]     <= 8'd33;
            r_addr[3]     <= 8'd41;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DIGIT_COUNT:  r_digit_count <= i_cfg_data[2:0];
                CFG_DIGIT_ADDR_0: r_addr[0]     <= i_cfg_data;
                CFG_DIGIT_ADDR_1: r_addr[1]     <= i_cfg_data;
                CFG_DIGIT_ADDR_2: r_addr[2]     <= i_cfg_data;
                CFG_DIGIT_ADDR_3: r_addr[3]     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nld_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_in_valid),
        .i_data        (i_in_data),
        .o_stall       (o_in_stall),
        .i_digit_count (r_digit_count),
        .o_push        (s_push),
        .o_work        (s_work),
        .i_full        (s_full)
    );

    nld_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_work),
        .o_full  (s_full),
        .i_pop   (s_pop),
        .o_data  (s_q_data),
        .o_empty (s_empty)
    );

    nld_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (s_empty),
        .i_q_data    (s_q_data),
        .o_pop       (s_pop),
        .i_addr      (r_addr),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire
